FILE: rtl/opacity_table_bilinear_lookup_core_assert.svh
// Assertion macros used by the lookup core.
`ifndef OPACITY_TABLE_BILINEAR_LOOKUP_CORE_ASSERT_SVH
`define OPACITY_TABLE_BILINEAR_LOOKUP_CORE_ASSERT_SVH

// Property checked on every rising clock edge, off while reset is low.
`define OTBL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define OTBL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `OTBL_ASSERT(lbl, clk, rstn, (ante) |=> (cons))

`endif

FILE: rtl/otbl_pkg.sv
package otbl_pkg;

  // Fixed point formats (16 fraction bits)
  localparam int unsigned QW  = 24;  // table and result words
  localparam int unsigned RW  = 27;  // ratio axis value
  localparam int unsigned DYW = 25;  // y1 - y0
  localparam int unsigned DXW = 28;  // x - x0
  localparam int unsigned PW  = DYW + DXW;  // product
  localparam int unsigned CW  = 6;   // divider step counter

  localparam logic signed [RW-1:0] TEMP_OFFSET = 27'sd393216;  // 6.0
  localparam logic signed [QW-1:0] Q_MAX = 24'sh7FFFFF;
  localparam logic signed [QW-1:0] Q_MIN = 24'sh800000;

  // Commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Clamp flags
  localparam logic [1:0] FLAG_NONE = 2'd0;
  localparam logic [1:0] FLAG_LOW  = 2'd1;
  localparam logic [1:0] FLAG_HIGH = 2'd2;

  // Linear steps: two along the ratio axis, then one along temperature
  localparam logic [1:0] LERP_ROW0 = 2'd0;
  localparam logic [1:0] LERP_ROW1 = 2'd1;
  localparam logic [1:0] LERP_TEMP = 2'd2;

  // Fetch slots after the searches
  localparam logic [3:0] FT_R0   = 4'd0;
  localparam logic [3:0] FT_R1   = 4'd1;
  localparam logic [3:0] FT_T0   = 4'd2;
  localparam logic [3:0] FT_T1   = 4'd3;
  localparam logic [3:0] FT_C00  = 4'd4;
  localparam logic [3:0] FT_C01  = 4'd5;
  localparam logic [3:0] FT_C10  = 4'd6;
  localparam logic [3:0] FT_C11  = 4'd7;
  localparam logic [3:0] FT_DONE = 4'd8;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_TRD   = 9'b000000010,
    ST_TCMP  = 9'b000000100,
    ST_RRD   = 9'b000001000,
    ST_RCMP  = 9'b000010000,
    ST_FETCH = 9'b000100000,
    ST_MUL   = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_ACC   = 9'b100000000
  } state_e;

endpackage

FILE: rtl/opacity_table_bilinear_lookup_core.sv
// Bilinear log-opacity table lookup.
// Requests enter on start while busy is low. command_i = 0 writes table_word_i
// at (row_i, col_i) in that same cycle and produces no result; busy stays low.
// command_i = 1 starts a lookup with log_temp_i and log_density_i; busy goes
// high on the next cycle until the result is out.
// A lookup result sits on log_opacity_o and the clamp flags for one cycle
// with done_o high; the receiver has no way to stall it.
// A lookup searches the temperature rows, a read and a compare per row,
// then the ratio columns the same way, fetches the axis and corner words,
// and runs three linear steps on one shared multiply / restoring divide unit
// (the divide is skipped when the axis step is zero) before done_o. The
// single read port of the table and the bit-serial divider set the lookup
// time; one lookup runs at a time.
// rows_q and cols_q are written through cfg_we_i / cfg_idx_i / cfg_wdata_i;
// the user must do so only while idle, the block does not enforce it. Reset
// clears the sequencer and sets them to 128 rows and 32 columns; table
// contents are not cleared and must be written before they are looked up.
`include "opacity_table_bilinear_lookup_core_assert.svh"

module opacity_table_bilinear_lookup_core #(
  parameter int unsigned TEMP_ROWS  = 128,
  parameter int unsigned RATIO_COLS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [7:0]               cfg_wdata_i,
  input  logic                     start,
  output logic                     busy,
  input  logic                     command_i,
  input  logic [6:0]               row_i,
  input  logic [4:0]               col_i,
  input  logic signed [23:0]       table_word_i,
  input  logic signed [23:0]       log_temp_i,
  input  logic signed [23:0]       log_density_i,
  output logic                     done_o,
  output logic signed [23:0]       log_opacity_o,
  output logic [1:0]               temp_clamped_o,
  output logic [1:0]               ratio_clamped_o
);

  localparam int unsigned RB    = $clog2(TEMP_ROWS);
  localparam int unsigned CB    = $clog2(RATIO_COLS);
  localparam int unsigned AW    = RB + CB;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned TIW   = $clog2(TEMP_ROWS + 1);
  localparam int unsigned RJW   = $clog2(RATIO_COLS + 1);
  localparam int unsigned QW    = otbl_pkg::QW;
  localparam int unsigned RW    = otbl_pkg::RW;
  localparam int unsigned PW    = otbl_pkg::PW;
  localparam int unsigned CW    = otbl_pkg::CW;

  // Configuration registers
  logic [7:0] rows_q;
  logic [5:0] cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 8'd128;
      cols_q <= 6'd32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        otbl_pkg::REG_ROWS: rows_q <= cfg_wdata_i;
        otbl_pkg::REG_COLS: cols_q <= cfg_wdata_i[5:0];
      endcase
    end
  end

  // Rows and columns in use, clamped to [3, limit]
  logic [8:0]     rows_w;
  logic [6:0]     cols_w;
  logic [TIW-1:0] nt;
  logic [RJW-1:0] nr;

  assign rows_w = {1'b0, rows_q};
  assign cols_w = {1'b0, cols_q};

  always_comb begin
    if (rows_w < 9'd3) begin
      nt = TIW'(3);
    end else if (rows_w > 9'(TEMP_ROWS)) begin
      nt = TIW'(TEMP_ROWS);
    end else begin
      nt = TIW'(rows_w);
    end
    if (cols_w < 7'd3) begin
      nr = RJW'(3);
    end else if (cols_w > 7'(RATIO_COLS)) begin
      nr = RJW'(RATIO_COLS);
    end else begin
      nr = RJW'(cols_w);
    end
  end

  // Sequencer and datapath registers
  otbl_pkg::state_e state_q, state_d;
  logic [TIW-1:0]   ti_q, ti_d;
  logic [RJW-1:0]   rj_q, rj_d;
  logic [3:0]       k_q, k_d;
  logic [1:0]       li_q, li_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             done_q, done_d;

  logic signed [QW-1:0] lt_q, lt_d;
  logic signed [RW-1:0] lr_q, lr_d;
  logic [1:0]           tflag_q, tflag_d, rflag_q, rflag_d;
  logic signed [QW-1:0] r0_q, r0_d, r1_q, r1_d, t0_q, t0_d, t1_q, t1_d;
  logic signed [QW-1:0] c00_q, c00_d, c01_q, c01_d, c10_q, c10_d, c11_q, c11_d;
  logic signed [QW-1:0] kmin_q, kmin_d, kmax_q, kmax_d;
  logic [PW-1:0]        num_q, num_d;
  logic [QW:0]          den_q, den_d;
  logic [QW+1:0]        rem_q, rem_d;
  logic                 neg_q, neg_d, zero_q, zero_d;
  logic signed [QW-1:0] res_q, res_d;
  logic [1:0]           tout_q, tout_d, rout_q, rout_d;

  // Table memory
  logic signed [QW-1:0] mem_q [DEPTH];
  logic signed [QW-1:0] rd_q;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [7:0]           wrow_w;
  logic [5:0]           wcol_w;
  logic [TIW-1:0]       rd_row;
  logic [RJW-1:0]       rd_col;

  assign wrow_w  = {1'b0, row_i};
  assign wcol_w  = {1'b0, col_i};
  assign mem_we  = start && !busy && (command_i == otbl_pkg::CMD_WRITE) &&
                   (9'(wrow_w) < 9'(TEMP_ROWS)) && (7'(wcol_w) < 7'(RATIO_COLS));
  assign wr_addr = {wrow_w[RB-1:0], wcol_w[CB-1:0]};
  assign rd_addr = {rd_row[RB-1:0], rd_col[CB-1:0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= table_word_i;
    end
    if (mem_re) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Ratio axis value of a new lookup: logR = rho - 3 * (T - 6)
  logic signed [RW-1:0] lt_off, lr_new;
  assign lt_off = RW'(log_temp_i) - otbl_pkg::TEMP_OFFSET;
  assign lr_new = RW'(log_density_i) - ((lt_off <<< 1) + lt_off);

  logic [TIW-1:0] ti_m1;
  logic [RJW-1:0] rj_m1;
  assign ti_m1 = ti_q - TIW'(1);
  assign rj_m1 = rj_q - RJW'(1);

  // Operand select of the shared linear step
  logic signed [QW-1:0] op_y0, op_y1, op_x0, op_x1;
  logic signed [RW-1:0] op_x;

  always_comb begin
    case (li_q)
      otbl_pkg::LERP_ROW0: begin
        op_y0 = c00_q; op_y1 = c01_q; op_x0 = r0_q; op_x1 = r1_q; op_x = lr_q;
      end
      otbl_pkg::LERP_ROW1: begin
        op_y0 = c10_q; op_y1 = c11_q; op_x0 = r0_q; op_x1 = r1_q; op_x = lr_q;
      end
      default: begin
        op_y0 = kmin_q; op_y1 = kmax_q; op_x0 = t0_q; op_x1 = t1_q;
        op_x  = RW'(lt_q);
      end
    endcase
  end

  // Multiply stage
  logic signed [QW:0]      dx, dy;
  logic signed [RW:0]      dxx;
  logic signed [PW-1:0]    prod;
  assign dx   = (QW+1)'(op_x1) - (QW+1)'(op_x0);
  assign dy   = (QW+1)'(op_y1) - (QW+1)'(op_y0);
  assign dxx  = (RW+1)'(op_x) - (RW+1)'(op_x0);
  assign prod = PW'(dy) * PW'(dxx);

  // Divide step: one quotient bit per cycle
  logic [QW+1:0] rem_sh;
  logic          take;
  assign rem_sh = {rem_q[QW:0], num_q[PW-1]};
  assign take   = rem_sh >= {1'b0, den_q};

  // Accumulate and saturate
  logic signed [PW:0]   qs;
  logic signed [PW+1:0] sum;
  logic signed [QW-1:0] sat;
  assign qs  = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
  assign sum = zero_q ? (PW+2)'(op_y0) : ((PW+2)'(op_y0) + (PW+2)'(qs));

  always_comb begin
    if (sum > (PW+2)'(otbl_pkg::Q_MAX)) begin
      sat = otbl_pkg::Q_MAX;
    end else if (sum < (PW+2)'(otbl_pkg::Q_MIN)) begin
      sat = otbl_pkg::Q_MIN;
    end else begin
      sat = sum[QW-1:0];
    end
  end

  assign busy = (state_q != otbl_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    ti_d = ti_q; rj_d = rj_q; k_d = k_q; li_d = li_q; cnt_d = cnt_q;
    done_d = 1'b0;
    lt_d = lt_q; lr_d = lr_q; tflag_d = tflag_q; rflag_d = rflag_q;
    r0_d = r0_q; r1_d = r1_q; t0_d = t0_q; t1_d = t1_q;
    c00_d = c00_q; c01_d = c01_q; c10_d = c10_q; c11_d = c11_q;
    kmin_d = kmin_q; kmax_d = kmax_q;
    num_d = num_q; den_d = den_q; rem_d = rem_q; neg_d = neg_q; zero_d = zero_q;
    res_d = res_q; tout_d = tout_q; rout_d = rout_q;
    mem_re = 1'b0;
    rd_row = '0;
    rd_col = '0;

    unique case (state_q)
      otbl_pkg::ST_IDLE: begin
        if (start && command_i == otbl_pkg::CMD_LOOKUP) begin
          lt_d    = log_temp_i;
          lr_d    = lr_new;
          ti_d    = TIW'(1);
          rj_d    = RJW'(1);
          tflag_d = otbl_pkg::FLAG_NONE;
          rflag_d = otbl_pkg::FLAG_NONE;
          state_d = otbl_pkg::ST_TRD;
        end
      end

      // Temperature axis search, column 0
      otbl_pkg::ST_TRD: begin
        rd_row = ti_q;
        if (ti_q < nt) begin
          mem_re  = 1'b1;
          state_d = otbl_pkg::ST_TCMP;
        end else begin
          ti_d    = nt - TIW'(1);
          tflag_d = otbl_pkg::FLAG_HIGH;
          state_d = otbl_pkg::ST_RRD;
        end
      end
      otbl_pkg::ST_TCMP: begin
        if (rd_q < lt_q) begin
          ti_d    = ti_q + TIW'(1);
          state_d = otbl_pkg::ST_TRD;
        end else begin
          if (ti_q == TIW'(1)) begin
            ti_d    = TIW'(2);
            tflag_d = otbl_pkg::FLAG_LOW;
          end
          state_d = otbl_pkg::ST_RRD;
        end
      end

      // Ratio axis search, row 0
      otbl_pkg::ST_RRD: begin
        rd_col = rj_q;
        if (rj_q < nr) begin
          mem_re  = 1'b1;
          state_d = otbl_pkg::ST_RCMP;
        end else begin
          rj_d    = nr - RJW'(1);
          rflag_d = otbl_pkg::FLAG_HIGH;
          k_d     = otbl_pkg::FT_R0;
          state_d = otbl_pkg::ST_FETCH;
        end
      end
      otbl_pkg::ST_RCMP: begin
        if (RW'(rd_q) < lr_q) begin
          rj_d    = rj_q + RJW'(1);
          state_d = otbl_pkg::ST_RRD;
        end else begin
          if (rj_q == RJW'(1)) begin
            rj_d    = RJW'(2);
            rflag_d = otbl_pkg::FLAG_LOW;
          end
          k_d     = otbl_pkg::FT_R0;
          state_d = otbl_pkg::ST_FETCH;
        end
      end

      // Axis and corner fetch: read slot k, capture slot k - 1
      otbl_pkg::ST_FETCH: begin
        mem_re = (k_q != otbl_pkg::FT_DONE);
        case (k_q)
          otbl_pkg::FT_R0:  begin rd_row = '0;    rd_col = rj_m1; end
          otbl_pkg::FT_R1:  begin rd_row = '0;    rd_col = rj_q;  end
          otbl_pkg::FT_T0:  begin rd_row = ti_m1; rd_col = '0;    end
          otbl_pkg::FT_T1:  begin rd_row = ti_q;  rd_col = '0;    end
          otbl_pkg::FT_C00: begin rd_row = ti_m1; rd_col = rj_m1; end
          otbl_pkg::FT_C01: begin rd_row = ti_m1; rd_col = rj_q;  end
          otbl_pkg::FT_C10: begin rd_row = ti_q;  rd_col = rj_m1; end
          otbl_pkg::FT_C11: begin rd_row = ti_q;  rd_col = rj_q;  end
          default: begin rd_row = '0; rd_col = '0; end
        endcase
        case (k_q)
          otbl_pkg::FT_R1: begin
            r0_d = rd_q;
            if (rflag_q == otbl_pkg::FLAG_LOW) lr_d = RW'(rd_q);
          end
          otbl_pkg::FT_T0: begin
            r1_d = rd_q;
            if (rflag_q == otbl_pkg::FLAG_HIGH) lr_d = RW'(rd_q);
          end
          otbl_pkg::FT_T1: begin
            t0_d = rd_q;
            if (tflag_q == otbl_pkg::FLAG_LOW) lt_d = rd_q;
          end
          otbl_pkg::FT_C00: begin
            t1_d = rd_q;
            if (tflag_q == otbl_pkg::FLAG_HIGH) lt_d = rd_q;
          end
          otbl_pkg::FT_C01: c00_d = rd_q;
          otbl_pkg::FT_C10: c01_d = rd_q;
          otbl_pkg::FT_C11: c10_d = rd_q;
          otbl_pkg::FT_DONE: c11_d = rd_q;
          default: ;
        endcase
        if (k_q == otbl_pkg::FT_DONE) begin
          li_d    = otbl_pkg::LERP_ROW0;
          state_d = otbl_pkg::ST_MUL;
        end else begin
          k_d = k_q + 4'd1;
        end
      end

      // Shared linear step: product, sign and divisor magnitude
      otbl_pkg::ST_MUL: begin
        num_d   = prod[PW-1] ? PW'(-prod) : PW'(prod);
        den_d   = dx[QW] ? (QW+1)'(-dx) : (QW+1)'(dx);
        neg_d   = prod[PW-1] ^ dx[QW];
        zero_d  = (dx == '0);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = (dx == '0) ? otbl_pkg::ST_ACC : otbl_pkg::ST_DIV;
      end
      otbl_pkg::ST_DIV: begin
        rem_d = take ? (rem_sh - {1'b0, den_q}) : rem_sh;
        num_d = {num_q[PW-2:0], take};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(PW - 1)) begin
          state_d = otbl_pkg::ST_ACC;
        end
      end
      otbl_pkg::ST_ACC: begin
        case (li_q)
          otbl_pkg::LERP_ROW0: begin
            kmin_d  = sat;
            li_d    = otbl_pkg::LERP_ROW1;
            state_d = otbl_pkg::ST_MUL;
          end
          otbl_pkg::LERP_ROW1: begin
            kmax_d  = sat;
            li_d    = otbl_pkg::LERP_TEMP;
            state_d = otbl_pkg::ST_MUL;
          end
          default: begin
            res_d   = sat;
            tout_d  = tflag_q;
            rout_d  = rflag_q;
            done_d  = 1'b1;
            state_d = otbl_pkg::ST_IDLE;
          end
        endcase
      end
      default: state_d = otbl_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= otbl_pkg::ST_IDLE;
      ti_q    <= '0;
      rj_q    <= '0;
      k_q     <= '0;
      li_q    <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ti_q    <= ti_d;
      rj_q    <= rj_d;
      k_q     <= k_d;
      li_q    <= li_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    lt_q <= lt_d; lr_q <= lr_d; tflag_q <= tflag_d; rflag_q <= rflag_d;
    r0_q <= r0_d; r1_q <= r1_d; t0_q <= t0_d; t1_q <= t1_d;
    c00_q <= c00_d; c01_q <= c01_d; c10_q <= c10_d; c11_q <= c11_d;
    kmin_q <= kmin_d; kmax_q <= kmax_d;
    num_q <= num_d; den_q <= den_d; rem_q <= rem_d; neg_q <= neg_d;
    zero_q <= zero_d;
    res_q <= res_d; tout_q <= tout_d; rout_q <= rout_d;
  end

  assign done_o          = done_q;
  assign log_opacity_o   = res_q;
  assign temp_clamped_o  = tout_q;
  assign ratio_clamped_o = rout_q;

  // Checks
  `OTBL_ASSERT_NEXT(a_done_after_last, clk_i, rst_ni, state_q == otbl_pkg::ST_ACC && li_q == otbl_pkg::LERP_TEMP, done_o)
  `OTBL_ASSERT_NEXT(a_lookup_busy, clk_i, rst_ni, start && !busy && command_i == otbl_pkg::CMD_LOOKUP, busy)
  `OTBL_ASSERT(a_tsearch_range, clk_i, rst_ni, (state_q == otbl_pkg::ST_TCMP) |-> (ti_q < nt))
  `OTBL_ASSERT(a_flags_valid, clk_i, rst_ni, done_o |-> (temp_clamped_o != 2'd3 && ratio_clamped_o != 2'd3))

endmodule

FILE: tb/opacity_table_bilinear_lookup_core_tb.sv
`timescale 1ns / 100ps

module opacity_table_bilinear_lookup_core_tb;

  localparam int ROWS = 128;
  localparam int COLS = 32;
  // every row is written in columns below FULL_COLS, every column in rows
  // below FULL_ROWS; tables in use keep nr <= FULL_COLS or nt <= FULL_ROWS
  localparam int FULL_COLS = 4;
  localparam int FULL_ROWS = 12;
  localparam int RANDOM_ITEMS = 900;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef enum int {AXIS_SORTED, AXIS_DUPS, AXIS_SCRAMBLED} axis_kind_e;

  typedef struct {
    logic signed [23:0] log_opacity;
    logic [1:0]         temp_flag;
    logic [1:0]         ratio_flag;
  } opacity_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = otbl_pkg::REG_ROWS;
  logic [7:0] cfg_wdata_i = '0;
  logic start = 1'b0;
  logic busy;
  logic command_i = otbl_pkg::CMD_WRITE;
  logic [6:0] row_i = '0;
  logic [4:0] col_i = '0;
  logic signed [23:0] table_word_i = '0;
  logic signed [23:0] log_temp_i = '0;
  logic signed [23:0] log_density_i = '0;
  logic done_o;
  logic signed [23:0] log_opacity_o;
  logic [1:0] temp_clamped_o;
  logic [1:0] ratio_clamped_o;

  // shadow copy of the block state
  logic signed [23:0] opacity_tbl [ROWS][COLS];
  logic [7:0] rows_reg;
  logic [5:0] cols_reg;
  opacity_result_t pending_results[$];
  int mismatches = 0;
  longint cycle_count = 0;

  opacity_table_bilinear_lookup_core uut (.*);

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic longint sat24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint lerp_sat(longint y0, longint y1, longint x0, longint x1,
                                      longint x);
    longint dx;
    dx = x1 - x0;
    if (dx == 0) return sat24(y0);
    return sat24(y0 + ((y1 - y0) * (x - x0)) / dx);
  endfunction

  function automatic longint cell_val(int r, int c);
    return longint'(opacity_tbl[r][c]);
  endfunction

  // bilinear lookup on the shadow table; pushes the expected result
  function automatic void predict_lookup(logic signed [23:0] lt_in, logic signed [23:0] ld_in);
    int nt, nr, ti, rj;
    longint lt, lr, kmin, kmax;
    opacity_result_t res;
    nt = (rows_reg < 3) ? 3 : (rows_reg > ROWS) ? ROWS : int'(rows_reg);
    nr = (cols_reg < 3) ? 3 : (cols_reg > COLS) ? COLS : int'(cols_reg);
    lt = longint'(lt_in);
    lr = longint'(ld_in) - 3 * (lt - 64'sd393216);
    res.temp_flag = otbl_pkg::FLAG_NONE;
    res.ratio_flag = otbl_pkg::FLAG_NONE;
    ti = 1;
    while (ti < nt && cell_val(ti, 0) < lt) ti++;
    if (ti == 1) begin
      ti = 2; lt = cell_val(1, 0); res.temp_flag = otbl_pkg::FLAG_LOW;
    end else if (ti == nt) begin
      ti = nt - 1; lt = cell_val(nt - 1, 0); res.temp_flag = otbl_pkg::FLAG_HIGH;
    end
    rj = 1;
    while (rj < nr && cell_val(0, rj) < lr) rj++;
    if (rj == 1) begin
      rj = 2; lr = cell_val(0, 1); res.ratio_flag = otbl_pkg::FLAG_LOW;
    end else if (rj == nr) begin
      rj = nr - 1; lr = cell_val(0, nr - 1); res.ratio_flag = otbl_pkg::FLAG_HIGH;
    end
    kmin = lerp_sat(cell_val(ti - 1, rj - 1), cell_val(ti - 1, rj),
                    cell_val(0, rj - 1), cell_val(0, rj), lr);
    kmax = lerp_sat(cell_val(ti, rj - 1), cell_val(ti, rj),
                    cell_val(0, rj - 1), cell_val(0, rj), lr);
    res.log_opacity = 24'(lerp_sat(kmin, kmax, cell_val(ti - 1, 0), cell_val(ti, 0), lt));
    pending_results.push_back(res);
  endfunction

  // one request; entered and left at a falling edge, start left high
  task automatic send_req(logic cmd, logic [6:0] r, logic [4:0] c, logic signed [23:0] w,
                          logic signed [23:0] lt, logic signed [23:0] ld);
    command_i = cmd; row_i = r; col_i = c;
    table_word_i = w; log_temp_i = lt; log_density_i = ld;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (cmd == otbl_pkg::CMD_WRITE) opacity_tbl[r][c] = w;
    else predict_lookup(lt, ld);
    @(negedge clk_i);
  endtask

  task automatic write_word(int r, int c, logic signed [23:0] w);
    send_req(otbl_pkg::CMD_WRITE, 7'(r), 5'(c), w, 24'($urandom), 24'($urandom));
  endtask

  task automatic lookup(logic signed [23:0] lt, logic signed [23:0] ld);
    send_req(otbl_pkg::CMD_LOOKUP, 7'($urandom), 5'($urandom), 24'($urandom), lt, ld);
  endtask

  task automatic pause(int n);
    start = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // hold off until all results are back and the block is idle
  task automatic drain();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    drain();
    cfg_idx_i = idx; cfg_wdata_i = val; cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == otbl_pkg::REG_ROWS) rows_reg = val;
    else cols_reg = val[5:0];
  endtask

  // rewrite both axes over the whole table
  task automatic load_axes(axis_kind_e kind);
    longint v;
    v = longint'($urandom_range(0, 262144)) + 64'sd131072;
    for (int r = 1; r < ROWS; r++) begin
      if (kind == AXIS_SCRAMBLED) v = longint'($urandom_range(0, 1048575)) - 64'sd524288 + 393216;
      else if (kind == AXIS_SORTED || $urandom_range(0, 3) != 0) v += $urandom_range(1, 8192);
      write_word(r, 0, 24'(v));
    end
    v = -longint'($urandom_range(0, 524288)) - 64'sd262144;
    for (int c = 1; c < COLS; c++) begin
      if (kind == AXIS_SCRAMBLED) v = longint'($urandom_range(0, 2097151)) - 64'sd1048576;
      else if (kind == AXIS_SORTED || $urandom_range(0, 3) != 0) v += $urandom_range(1, 40000);
      write_word(0, c, 24'(v));
    end
  endtask

  // a lookup aimed near the axes in use, ratio built from the target
  task automatic aimed_lookup();
    int nt, nr;
    longint lt, lr, ld;
    nt = (rows_reg < 3) ? 3 : (rows_reg > ROWS) ? ROWS : int'(rows_reg);
    nr = (cols_reg < 3) ? 3 : (cols_reg > COLS) ? COLS : int'(cols_reg);
    lt = cell_val($urandom_range(1, nt - 1), 0) + $urandom_range(0, 16384) - 8192;
    lr = cell_val(0, $urandom_range(1, nr - 1)) + $urandom_range(0, 60000) - 30000;
    if ($urandom_range(0, 7) == 0) lt = cell_val($urandom_range(1, nt - 1), 0);
    if ($urandom_range(0, 7) == 0) lr = cell_val(0, $urandom_range(1, nr - 1));
    ld = sat24(lr + 3 * (lt - 393216));
    lookup(24'(lt), 24'(ld));
  endtask

  // every entry that a table in use can reach is written once
  task automatic test_fill_table();
    for (int r = 1; r < ROWS; r++)
      for (int c = 1; c < COLS; c++)
        if (c < FULL_COLS || r < FULL_ROWS)
          write_word(r, c, 24'(longint'($urandom_range(0, 2097151)) - 64'sd1048576));
    write_word(0, 0, 24'($urandom));
    load_axes(AXIS_SORTED);
  endtask

  task automatic test_directed();
    // register values below range saturate to the smallest table
    write_reg(otbl_pkg::REG_ROWS, 8'd0);
    write_reg(otbl_pkg::REG_COLS, 8'd0);
    write_word(1, 0, 24'sd327680);
    write_word(2, 0, 24'sd393216);
    write_word(0, 1, -24'sd131072);
    write_word(0, 2, 24'sd65536);
    write_word(1, 1, 24'sh7FFFFF);
    write_word(1, 2, 24'sh800000);
    write_word(2, 1, 24'sd0);
    write_word(2, 2, 24'sd65536);
    lookup(24'sh800000, 24'sh800000);
    lookup(24'sh7FFFFF, 24'sh7FFFFF);
    lookup(24'sh7FFFFF, 24'sh800000);
    lookup(24'sd327680, -24'sd131072 + 3 * (327680 - 393216));
    lookup(24'sd393216, 24'sd65536);
    lookup(24'sd360000, 24'sd0 + 3 * (360000 - 393216));
    // equal neighboring axis points
    write_word(2, 0, 24'sd327680);
    write_word(0, 2, -24'sd131072);
    lookup(24'sd327680, 24'sd0);
    lookup(24'sd400000, 24'sd500000);
    // out-of-range row count saturates to all rows
    write_reg(otbl_pkg::REG_ROWS, 8'd255);
    write_reg(otbl_pkg::REG_COLS, 8'(FULL_COLS));
    load_axes(AXIS_SORTED);
    lookup(24'sh800000, 24'sh7FFFFF);
    lookup(24'sh7FFFFF, 24'sh7FFFFF);
    aimed_lookup();
    aimed_lookup();
    // out-of-range column count saturates to all columns
    write_reg(otbl_pkg::REG_ROWS, 8'(FULL_ROWS));
    write_reg(otbl_pkg::REG_COLS, 8'd63);
    aimed_lookup();
    aimed_lookup();
    lookup(24'sd0, 24'sd0);
    write_reg(otbl_pkg::REG_COLS, 8'd32);
    aimed_lookup();
  endtask

  task automatic test_random();
    int sent, burst_left, per_phase;
    logic no_gaps;
    sent = 0;
    burst_left = 0;
    while (sent < RANDOM_ITEMS) begin
      // new phase: mostly small tables, now and then the largest shapes
      case ($urandom_range(0, 9))
        0: begin
          write_reg(otbl_pkg::REG_ROWS, 8'd128);
          write_reg(otbl_pkg::REG_COLS, 8'(FULL_COLS));
        end
        1: begin write_reg(otbl_pkg::REG_ROWS, 8'd3); write_reg(otbl_pkg::REG_COLS, 8'd3); end
        2: begin
          write_reg(otbl_pkg::REG_ROWS, 8'($urandom));
          if (rows_reg > FULL_ROWS)
            write_reg(otbl_pkg::REG_COLS, 8'($urandom_range(0, FULL_COLS)));
          else
            write_reg(otbl_pkg::REG_COLS, 8'($urandom));
        end
        3: begin
          write_reg(otbl_pkg::REG_ROWS, 8'(FULL_ROWS));
          write_reg(otbl_pkg::REG_COLS, 8'd32);
        end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            write_reg(otbl_pkg::REG_ROWS, 8'($urandom_range(3, FULL_ROWS)));
            write_reg(otbl_pkg::REG_COLS, 8'($urandom_range(3, 32)));
          end else begin
            write_reg(otbl_pkg::REG_ROWS, 8'($urandom_range(FULL_ROWS + 1, 128)));
            write_reg(otbl_pkg::REG_COLS, 8'($urandom_range(3, FULL_COLS)));
          end
        end
      endcase
      case ($urandom_range(0, 9))
        0: begin load_axes(AXIS_SCRAMBLED); sent += ROWS + COLS - 2; end
        1: begin load_axes(AXIS_DUPS); sent += ROWS + COLS - 2; end
        2: begin load_axes(AXIS_SORTED); sent += ROWS + COLS - 2; end
        default: ;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      per_phase = $urandom_range(20, 80);
      for (int k = 0; k < per_phase && sent < RANDOM_ITEMS; k++) begin
        if (!no_gaps && burst_left == 0) begin
          pause($urandom_range(1, 12));
          burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;
        case ($urandom_range(0, 9))
          0, 1: write_word($urandom_range(1, ROWS - 1), $urandom_range(1, COLS - 1),
                           ($urandom_range(0, 7) == 0) ? 24'($urandom) :
                           24'(longint'($urandom_range(0, 2097151)) - 64'sd1048576));
          2: lookup(24'($urandom), 24'($urandom));
          default: aimed_lookup();
        endcase
        sent++;
      end
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    opacity_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected lookup result %0d", log_opacity_o);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (log_opacity_o !== exp_res.log_opacity) begin
          $error("log_opacity expected %0d actual %0d", exp_res.log_opacity, log_opacity_o);
          mismatches++;
        end
        if (temp_clamped_o !== exp_res.temp_flag) begin
          $error("temp_clamped expected %0d actual %0d", exp_res.temp_flag, temp_clamped_o);
          mismatches++;
        end
        if (ratio_clamped_o !== exp_res.ratio_flag) begin
          $error("ratio_clamped expected %0d actual %0d", exp_res.ratio_flag,
                 ratio_clamped_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rows_reg = 8'd128;
    cols_reg = 6'd32;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_fill_table();
    test_directed();
    test_random();
    drain();
    repeat (600) @(negedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d lookup results never arrived", pending_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
